/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while reset is low.
`define VAT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define VAT_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/vat_pkg.sv */
`default_nettype none

package vat_pkg;

    localparam int CNT_W = 19;

    localparam logic [4:0] MAX_ELAPSED = 5'd16;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_TICK  = 2'd2,
        OP_CA1   = 2'd3
    } t_opcode;

    localparam logic [3:0] REG_ORB   = 4'd0;
    localparam logic [3:0] REG_ORA   = 4'd1;
    localparam logic [3:0] REG_DDRB  = 4'd2;
    localparam logic [3:0] REG_DDRA  = 4'd3;
    localparam logic [3:0] REG_T1CL  = 4'd4;
    localparam logic [3:0] REG_T1CH  = 4'd5;
    localparam logic [3:0] REG_T1LL  = 4'd6;
    localparam logic [3:0] REG_T1LH  = 4'd7;
    localparam logic [3:0] REG_T2CL  = 4'd8;
    localparam logic [3:0] REG_T2CH  = 4'd9;
    localparam logic [3:0] REG_SR    = 4'd10;
    localparam logic [3:0] REG_ACR   = 4'd11;
    localparam logic [3:0] REG_PCR   = 4'd12;
    localparam logic [3:0] REG_IFR   = 4'd13;
    localparam logic [3:0] REG_IER   = 4'd14;
    localparam logic [3:0] REG_ORA_NH = 4'd15;

    localparam int FLAG_CA2  = 0;
    localparam int FLAG_CA1  = 1;
    localparam int FLAG_T2   = 5;
    localparam int FLAG_T1   = 6;
    localparam int ACR_FREE  = 6;
    localparam int ACR_PB7   = 7;
    localparam int PCR_CA2_IND = 1;

    typedef struct packed {
        t_opcode    opcode;
        logic [3:0] reg_address;
        logic [7:0] write_data;
        logic [4:0] elapsed;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
        logic [7:0] port_b_out;
    } t_out_item;

endpackage

`default_nettype wire

/* rtl/vat_core.sv */
`default_nettype none

module vat_core
    import vat_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_advance,
    input  wire t_in_item  i_item,
    output t_out_item      o_result
);

    logic [7:0]       r_orb, r_irb, r_ddrb, r_ddra, r_acr, r_pcr;
    logic [15:0]      r_latch_one, r_latch_two;
    logic [CNT_W-1:0] r_count_one, r_count_two;
    logic [6:0]       r_flag, r_ier;
    logic             r_fired, r_two_adj;

    logic [7:0]       n_orb, n_irb, n_ddrb, n_ddra, n_acr, n_pcr;
    logic [15:0]      n_latch_one, n_latch_two;
    logic [CNT_W-1:0] n_count_one, n_count_two;
    logic [6:0]       n_flag, n_ier;
    logic             n_fired, n_two_adj;

    logic [7:0]       rd;
    logic [4:0]       el;
    logic [CNT_W-1:0] dec_one, dec_two, lat_one_x2, lat_two_x2;
    logic             irq_now;

    function automatic logic [7:0] f_count_byte(
        input logic [CNT_W-1:0] c,
        input logic [15:0]      lat,
        input logic             hi
    );
        logic signed [CNT_W:0] cx;
        logic signed [CNT_W:0] lim;
        logic [CNT_W:0]        s;
        cx  = {c[CNT_W-1], c};
        lim = {3'b000, lat, 1'b0};
        if (hi) begin
            s = cx + (c[CNT_W-1] ? 20'd511 : 20'd0);
        end else begin
            s = cx + {19'd0, c[CNT_W-1]};
        end
        if (cx > lim) begin
            return 8'hFF;
        end
        return hi ? s[16:9] : s[8:1];
    endfunction

    assign el         = (i_item.elapsed > MAX_ELAPSED) ? MAX_ELAPSED : i_item.elapsed;
    assign dec_one    = r_count_one - {14'd0, el};
    assign dec_two    = r_count_two - {14'd0, el};
    assign lat_one_x2 = {2'b00, r_latch_one, 1'b0};
    assign lat_two_x2 = {2'b00, r_latch_two, 1'b0};
    assign irq_now    = |(r_flag & r_ier);

    always_comb begin
        n_orb       = r_orb;
        n_irb       = r_irb;
        n_ddrb      = r_ddrb;
        n_ddra      = r_ddra;
        n_acr       = r_acr;
        n_pcr       = r_pcr;
        n_latch_one = r_latch_one;
        n_latch_two = r_latch_two;
        n_count_one = r_count_one;
        n_count_two = r_count_two;
        n_flag      = r_flag;
        n_ier       = r_ier;
        n_fired     = r_fired;
        n_two_adj   = r_two_adj;
        rd          = 8'hFF;

        unique case (i_item.opcode)
            OP_WRITE: begin
                unique case (i_item.reg_address)
                    REG_ORB: begin
                        n_orb = i_item.write_data;
                        if (!r_pcr[PCR_CA2_IND]) begin
                            n_flag[FLAG_CA2] = 1'b0;
                        end
                    end
                    REG_ORA: begin
                        n_flag[FLAG_CA1] = 1'b0;
                        n_flag[FLAG_CA2] = 1'b0;
                    end
                    REG_DDRB: n_ddrb = i_item.write_data;
                    REG_DDRA: n_ddra = i_item.write_data;
                    REG_T1CL, REG_T1LL: n_latch_one[7:0] = i_item.write_data;
                    REG_T1CH: begin
                        n_latch_one[15:8] = i_item.write_data;
                        n_count_one       = {2'b00, i_item.write_data, r_latch_one[7:0], 1'b0};
                        n_flag[FLAG_T1]   = 1'b0;
                        n_fired           = 1'b0;
                        if (r_acr[ACR_PB7]) begin
                            n_orb[7] = 1'b0;
                            n_irb[7] = 1'b0;
                        end
                    end
                    REG_T1LH: n_latch_one[15:8] = i_item.write_data;
                    REG_T2CL: n_latch_two[7:0] = i_item.write_data;
                    REG_T2CH: begin
                        n_latch_two[15:8] = i_item.write_data;
                        n_count_two       = {2'b00, i_item.write_data, r_latch_two[7:0], 1'b0};
                        n_flag[FLAG_T2]   = 1'b0;
                    end
                    REG_ACR: n_acr = i_item.write_data;
                    REG_PCR: n_pcr = i_item.write_data;
                    REG_IFR: n_flag = r_flag & ~i_item.write_data[6:0];
                    REG_IER: begin
                        if (i_item.write_data[7]) begin
                            n_ier = r_ier | i_item.write_data[6:0];
                        end else begin
                            n_ier = r_ier & ~i_item.write_data[6:0];
                        end
                    end
                    default: ;
                endcase
            end
            OP_READ: begin
                unique case (i_item.reg_address)
                    REG_ORB:  rd = (r_orb & r_ddrb) | (r_irb & ~r_ddrb);
                    REG_ORA: begin
                        n_flag[FLAG_CA1] = 1'b0;
                        n_flag[FLAG_CA2] = 1'b0;
                    end
                    REG_DDRB: rd = r_ddrb;
                    REG_DDRA: rd = r_ddra;
                    REG_T1CL: begin
                        n_flag[FLAG_T1] = 1'b0;
                        rd = f_count_byte(r_count_one, r_latch_one, 1'b0);
                    end
                    REG_T1CH: rd = f_count_byte(r_count_one, r_latch_one, 1'b1);
                    REG_T1LL: rd = r_latch_one[7:0];
                    REG_T1LH: rd = r_latch_one[15:8];
                    REG_T2CL: begin
                        n_flag[FLAG_T2] = 1'b0;
                        rd = f_count_byte(r_count_two, r_latch_two, 1'b0);
                    end
                    REG_T2CH: rd = f_count_byte(r_count_two, r_latch_two, 1'b1);
                    REG_PCR:  rd = r_pcr;
                    REG_IFR:  rd = {irq_now, r_flag};
                    REG_IER:  rd = {1'b1, r_ier};
                    default:  rd = 8'hFF;
                endcase
            end
            OP_TICK: begin
                n_count_one = dec_one;
                n_count_two = dec_two;
                if (dec_one[CNT_W-1]) begin
                    n_count_one = lat_one_x2 + dec_one + 19'd4;
                    if (!r_fired || r_acr[ACR_FREE]) begin
                        n_flag[FLAG_T1] = 1'b1;
                        if (r_acr[ACR_PB7]) begin
                            n_orb[7] = ~r_orb[7];
                            n_irb[7] = ~r_irb[7];
                        end
                    end
                    n_fired = 1'b1;
                end
                if (dec_two[CNT_W-1]) begin
                    n_count_two     = lat_two_x2 - dec_two - 19'd3 - {18'd0, r_two_adj};
                    n_two_adj       = ~r_two_adj;
                    n_flag[FLAG_T2] = 1'b1;
                end
            end
            OP_CA1: n_flag[FLAG_CA1] = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orb       <= '0;
            r_irb       <= 8'hFF;
            r_ddrb      <= '0;
            r_ddra      <= '0;
            r_acr       <= '0;
            r_pcr       <= '0;
            r_latch_one <= '0;
            r_latch_two <= '0;
            r_count_one <= '0;
            r_count_two <= '0;
            r_flag      <= '0;
            r_ier       <= '0;
            r_fired     <= 1'b0;
            r_two_adj   <= 1'b0;
        end else if (i_advance) begin
            r_orb       <= n_orb;
            r_irb       <= n_irb;
            r_ddrb      <= n_ddrb;
            r_ddra      <= n_ddra;
            r_acr       <= n_acr;
            r_pcr       <= n_pcr;
            r_latch_one <= n_latch_one;
            r_latch_two <= n_latch_two;
            r_count_one <= n_count_one;
            r_count_two <= n_count_two;
            r_flag      <= n_flag;
            r_ier       <= n_ier;
            r_fired     <= n_fired;
            r_two_adj   <= n_two_adj;
        end
    end

    assign o_result.read_data  = rd;
    assign o_result.irq        = |(n_flag & n_ier);
    assign o_result.port_b_out = n_orb;

endmodule

`default_nettype wire

/* rtl/versatile_interface_adapter_timers.sv */
// Path: an accepted item is held in the input register, and its result then enters the
// result register, where o_out_valid goes high.
// Throughput: one item per cycle while the result register is not held; the register state
// updates as an item leaves the input register, and a full result register stalls the input side only when it is held.
// Reset (i_rst_n low, synchronous): both stages empty, all adapter registers to their
// reset values (port B input latch all ones, everything else zero).
`default_nettype none

module versatile_interface_adapter_timers
    import vat_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_item
);

    logic      r_in_valid, r_out_valid;
    t_in_item  r_in_item;
    t_out_item r_out_item;
    t_out_item result;
    logic      out_free, advance;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    vat_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= advance;
            end
        end
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

/* rtl/vat_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module vat_checker
    import vat_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_item
);

    `VAT_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "result dropped while stalled")
    `VAT_ASSERT(a_out_stable, o_out_valid && i_out_stall |=> $stable(o_out_item), "stalled result changed")
    `VAT_ASSERT(a_stall_cause, o_in_stall |-> o_out_valid && i_out_stall, "input stalled without held result")
    `VAT_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_out_valid && !o_in_stall, "pipeline not empty after reset")

endmodule

bind versatile_interface_adapter_timers vat_checker u_vat_checker (.*);

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

import vat_pkg::*;

class adapter_scoreboard;
    logic [7:0]  orb, ora, irb, ddrb, ddra, acr, pcr, ifr;
    logic [6:0]  ier;
    logic [15:0] t1_latch, t2_latch;
    int          t1_count, t2_count;
    bit          t1_fired, t2_adjust;
    t_out_item   bus_replies[$];
    int          errors;
    int          checked;
    int          op_seen[4];

    function new();
        orb = '0; ora = '0; irb = 8'hFF; ddrb = '0; ddra = '0;
        acr = '0; pcr = '0; ifr = '0; ier = '0;
        t1_latch = '0; t2_latch = '0; t1_count = 0; t2_count = 0;
        t1_fired = 0; t2_adjust = 0;
        errors = 0; checked = 0;
        foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    // counters are 19-bit two's complement
    function int fold19(int v);
        logic signed [18:0] s;
        s = v[18:0];
        return s;
    endfunction

    function void update_irq();
        ifr[7] = |(ifr[6:0] & ier);
    endfunction

    function logic [7:0] timer_byte(int c, logic [15:0] lat, int div);
        int q;
        if (c > int'(lat) * 2) return 8'hFF;
        q = c / div;
        return q[7:0];
    endfunction

    function t_out_item apply_item(t_in_item it);
        t_out_item  r;
        logic [7:0] d;
        int         span;
        int         t;
        d = it.write_data;
        r.read_data = 8'hFF;
        case (it.opcode)
            OP_WRITE: begin
                case (it.reg_address)
                    REG_ORB: begin
                        orb = d;
                        if (ifr[FLAG_CA2] && !pcr[PCR_CA2_IND]) begin
                            ifr[FLAG_CA2] = 1'b0;
                            update_irq();
                        end
                    end
                    REG_ORA: begin
                        ora = d;
                        ifr[FLAG_CA2] = 1'b0;
                        ifr[FLAG_CA1] = 1'b0;
                        update_irq();
                    end
                    REG_DDRB: ddrb = d;
                    REG_DDRA: ddra = d;
                    REG_T1CL, REG_T1LL: t1_latch[7:0] = d;
                    REG_T1CH: begin
                        t1_latch[15:8] = d;
                        t1_count = fold19(int'(t1_latch) * 2);
                        ifr[FLAG_T1] = 1'b0;
                        t1_fired = 0;
                        if (acr[ACR_PB7]) begin
                            orb[7] = 1'b0;
                            irb[7] = 1'b0;
                        end
                        update_irq();
                    end
                    REG_T1LH: t1_latch[15:8] = d;
                    REG_T2CL: t2_latch[7:0] = d;
                    REG_T2CH: begin
                        t2_latch[15:8] = d;
                        t2_count = fold19(int'(t2_latch) * 2);
                        ifr[FLAG_T2] = 1'b0;
                        update_irq();
                    end
                    REG_ACR: acr = d;
                    REG_PCR: pcr = d;
                    REG_IFR: begin
                        ifr = ifr & ~d;
                        update_irq();
                    end
                    REG_IER: begin
                        if (d[7]) ier = ier | d[6:0];
                        else ier = ier & ~d[6:0];
                        update_irq();
                    end
                    REG_ORA_NH: ora = d;
                    default: ;
                endcase
            end
            OP_READ: begin
                case (it.reg_address)
                    REG_ORB: r.read_data = (orb & ddrb) | (irb & ~ddrb);
                    REG_ORA: begin
                        ifr[FLAG_CA2] = 1'b0;
                        ifr[FLAG_CA1] = 1'b0;
                        update_irq();
                    end
                    REG_DDRB: r.read_data = ddrb;
                    REG_DDRA: r.read_data = ddra;
                    REG_T1CL: begin
                        ifr[FLAG_T1] = 1'b0;
                        update_irq();
                        r.read_data = timer_byte(t1_count, t1_latch, 2);
                    end
                    REG_T1CH: r.read_data = timer_byte(t1_count, t1_latch, 512);
                    REG_T1LL: r.read_data = t1_latch[7:0];
                    REG_T1LH: r.read_data = t1_latch[15:8];
                    REG_T2CL: begin
                        ifr[FLAG_T2] = 1'b0;
                        update_irq();
                        r.read_data = timer_byte(t2_count, t2_latch, 2);
                    end
                    REG_T2CH: r.read_data = timer_byte(t2_count, t2_latch, 512);
                    REG_PCR: r.read_data = pcr;
                    REG_IFR: begin
                        update_irq();
                        r.read_data = ifr;
                    end
                    REG_IER: r.read_data = {1'b1, ier};
                    default: ;
                endcase
            end
            OP_TICK: begin
                span = (it.elapsed > MAX_ELAPSED) ? int'(MAX_ELAPSED) : int'(it.elapsed);
                t1_count = fold19(t1_count - span);
                t2_count = fold19(t2_count - span);
                if (t1_count < 0) begin
                    t = -t1_count;
                    t1_count = fold19(int'(t1_latch) * 2 - (t - 4));
                    if (!t1_fired || acr[ACR_FREE]) begin
                        ifr[FLAG_T1] = 1'b1;
                        update_irq();
                        if (acr[ACR_PB7]) begin
                            orb[7] = ~orb[7];
                            irb[7] = ~irb[7];
                        end
                    end
                    t1_fired = 1;
                end
                if (t2_count < 0) begin
                    t = -t2_count;
                    t2_count = fold19(int'(t2_latch) * 2 + (t - (3 + int'(t2_adjust))));
                    t2_adjust = ~t2_adjust;
                    if (!ifr[FLAG_T2]) begin
                        ifr[FLAG_T2] = 1'b1;
                        update_irq();
                    end
                end
            end
            default: begin
                ifr[FLAG_CA1] = 1'b1;
                update_irq();
            end
        endcase
        r.irq = ifr[7];
        r.port_b_out = orb;
        return r;
    endfunction

    function void note_input(t_in_item it);
        op_seen[it.opcode]++;
        bus_replies.push_back(apply_item(it));
    endfunction

    function void check_result(t_out_item got);
        t_out_item want;
        checked++;
        if (bus_replies.size() == 0) begin
            errors++;
            $display("%0t: unexpected item %h, nothing expected", $time, got);
            return;
        end
        want = bus_replies.pop_front();
        if (got.read_data !== want.read_data) begin
            errors++;
            $display("%0t: read_data expected %02h, actual %02h",
                     $time, want.read_data, got.read_data);
        end
        if (got.irq !== want.irq) begin
            errors++;
            $display("%0t: irq expected %0b, actual %0b", $time, want.irq, got.irq);
        end
        if (got.port_b_out !== want.port_b_out) begin
            errors++;
            $display("%0t: port_b_out expected %02h, actual %02h",
                     $time, want.port_b_out, got.port_b_out);
        end
    endfunction

    function int pending();
        return bus_replies.size();
    endfunction
endclass

module tb;
    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    bit sender_idles = 1;
    bit receiver_stalls = 1;

    adapter_scoreboard sb = new();

    versatile_interface_adapter_timers dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_stall = receiver_stalls && ($urandom_range(0, 99) < 17);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_stall === 1'b0) sb.note_input(i_in_item);
            if (o_out_valid === 1'b1 && !i_out_stall) sb.check_result(o_out_item);
        end
    end

    task automatic send_item(input t_opcode op, input logic [3:0] addr,
                             input logic [7:0] data, input logic [4:0] el);
        @(negedge i_clk);
        if (sender_idles) begin
            while ($urandom_range(0, 99) < 17) begin
                i_in_valid = 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_item.opcode      = op;
        i_in_item.reg_address = addr;
        i_in_item.write_data  = data;
        i_in_item.elapsed     = el;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // short latch periods so both timers underflow often
    task automatic run_random(input int count);
        t_opcode    op;
        logic [3:0] addr;
        logic [7:0] data;
        logic [4:0] el;
        int         roll;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            addr = 4'($urandom_range(0, 15));
            data = 8'($urandom_range(0, 255));
            el   = 5'($urandom_range(0, 16));
            if (roll < 33) begin
                op = OP_WRITE;
                if ((addr == REG_T1CH || addr == REG_T1LH || addr == REG_T2CH)
                        && $urandom_range(0, 3) != 0)
                    data = 8'($urandom_range(0, 1));
                else if ((addr == REG_T1CL || addr == REG_T1LL || addr == REG_T2CL)
                        && $urandom_range(0, 3) != 0)
                    data = 8'($urandom_range(0, 40));
            end else if (roll < 63) begin
                op = OP_READ;
            end else if (roll < 93) begin
                op = OP_TICK;
                if ($urandom_range(0, 9) == 0) el = 5'($urandom_range(17, 31));
            end else begin
                op = OP_CA1;
                el = 5'($urandom_range(0, 31));
            end
            send_item(op, addr, data, el);
        end
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(OP_WRITE, REG_IER, 8'hFF, 5'd0);
        send_item(OP_WRITE, REG_T1LL, 8'hFF, 5'd0);
        send_item(OP_WRITE, REG_T1CH, 8'hFF, 5'd0);
        send_item(OP_READ, REG_T1CH, 8'h00, 5'd0);
        send_item(OP_WRITE, REG_T1LL, 8'h00, 5'd0);
        // counter now above twice the latch
        send_item(OP_READ, REG_T1CL, 8'h00, 5'd0);
        send_item(OP_READ, REG_T1LH, 8'h00, 5'd0);
        send_item(OP_WRITE, REG_T1CH, 8'h00, 5'd0);
        send_item(OP_WRITE, REG_T2CH, 8'h00, 5'd0);
        send_item(OP_TICK, 4'd0, 8'h00, 5'd31);
        // negative timer 1 counter; timer 2 counter has reloaded to a positive count
        send_item(OP_READ, REG_T1CL, 8'h00, 5'd0);
        send_item(OP_READ, REG_T2CL, 8'h00, 5'd0);
        send_item(OP_WRITE, REG_ACR, 8'hC0, 5'd0);
        send_item(OP_WRITE, REG_T1CL, 8'h03, 5'd0);
        send_item(OP_WRITE, REG_T1CH, 8'h00, 5'd0);
        send_item(OP_TICK, 4'd0, 8'h00, 5'd16);
        send_item(OP_TICK, 4'd0, 8'h00, 5'd0);
        send_item(OP_TICK, 4'd0, 8'h00, 5'd16);
        send_item(OP_CA1, 4'd0, 8'h00, 5'd0);
        send_item(OP_READ, REG_IFR, 8'h00, 5'd0);
        send_item(OP_READ, REG_ORA, 8'h00, 5'd0);
        send_item(OP_WRITE, REG_DDRB, 8'h0F, 5'd0);
        send_item(OP_WRITE, REG_ORB, 8'hA5, 5'd0);
        send_item(OP_READ, REG_ORB, 8'h00, 5'd0);
        send_item(OP_WRITE, REG_SR, 8'h55, 5'd0);
        send_item(OP_WRITE, REG_ORA_NH, 8'h5A, 5'd0);
        send_item(OP_WRITE, REG_IER, 8'h7F, 5'd0);
        send_item(OP_READ, REG_IER, 8'h00, 5'd0);

        run_random(800);
        wait_drained();
        sender_idles = 0;
        receiver_stalls = 0;
        run_random(300);
        sender_idles = 1;
        receiver_stalls = 1;
        run_random(550);
        wait_drained();
        repeat (4) @(posedge i_clk);

        $display("Ran %0d writes, %0d reads, %0d ticks, %0d CA1 edges; %0d results checked.",
                 sb.op_seen[OP_WRITE], sb.op_seen[OP_READ], sb.op_seen[OP_TICK],
                 sb.op_seen[OP_CA1], sb.checked);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("Timed out with %0d items outstanding", sb.pending());
        $display("Test completed with failures");
        $finish;
    end
endmodule

/* sim.f */
+incdir+rtl
rtl/vat_pkg.sv
rtl/vat_core.sv
rtl/versatile_interface_adapter_timers.sv
rtl/vat_checker.sv
tb/sv/tb.sv
